// File: sv/mbc_pkg.sv
// maze backtracker carver package: field widths, codes and default sizes
// used by sv/maze_backtracker_carver.sv; depends on nothing else
package mbc_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // fixed field widths
  localparam int GRID_W  = 7;
  localparam int START_W = 6;
  localparam int POS_W   = 6;
  localparam int DIST_W  = 13;
  localparam int CFG_AW  = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_GRID_COLS = 2'd0,
    REG_GRID_ROWS = 2'd1,
    REG_START_COL = 2'd2,
    REG_START_ROW = 2'd3
  } cfg_reg_t;

  // result kinds
  typedef enum logic [1:0] {
    EV_REJECT = 2'd0,
    EV_CARVE  = 2'd1,
    EV_BACK   = 2'd2,
    EV_DONE   = 2'd3
  } event_kind_t;

  // draw directions
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // output beat payload layout
  localparam int OUT_BITS = 2 * POS_W + 2 + 2 * DIST_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

// File: sv/maze_backtracker_carver.sv
// depth-first maze carver: visited rows and path stack in synchronous memories
// depends on mbc_pkg (sv/mbc_pkg.sv)

// A draw is taken only on fresh read data: the visited map returns the rows
// above and below the current cell and the path stack returns the parent
// entry (both memories are read synchronously, addressed from the current
// state); on acceptance the state, the current visited row and the stack are
// updated, and the next draw waits for reads from the new state. The current
// row of the visited map is held in a register, so the four neighbour bits
// come from two memory reads. Each stack entry carries the cell's distance,
// so popping a cell restores its distance without a separate store. After
// reset and after every configuration write the visited map is cleared one
// row per cycle, all MAX_ROWS rows, during which no draw is taken;
// configuration writes are accepted at any time and restart the run. A result
// waits in an output register while the next draw's reads go ahead.
module maze_backtracker_carver #(
  parameter int MAX_COLS = mbc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = mbc_pkg::DEF_MAX_ROWS
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [mbc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [mbc_pkg::GRID_W-1:0] cfg_wdata,
  // draw input
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [1:0] rand_dir
  // result output
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [5:0] cell_col, [11:6] cell_row, [13:12] carve_dir, [26:14] cell_distance,
  // [39:27] max_distance, [40] finished
  output logic [mbc_pkg::OUT_W-1:0]  m_tdata,
  output logic [1:0]                 m_tuser    // [1:0] event_kind
);
  import mbc_pkg::*;

  localparam int CW          = $clog2(MAX_COLS);
  localparam int RW          = $clog2(MAX_ROWS);
  localparam int CUW         = $clog2(MAX_COLS + 1);
  localparam int RUW         = $clog2(MAX_ROWS + 1);
  localparam int STACK_DEPTH = MAX_COLS * MAX_ROWS + 1;
  localparam int SAW         = $clog2(STACK_DEPTH);
  localparam int SPW         = $clog2(STACK_DEPTH + 1);
  localparam int STK_W       = DIST_W + RW + CW;
  localparam int CMP_W       = 10;

  // configuration registers
  logic [GRID_W-1:0]  grid_cols;
  logic [GRID_W-1:0]  grid_rows;
  logic [START_W-1:0] start_col;
  logic [START_W-1:0] start_row;

  // run state
  logic [CW-1:0]       cur_col;
  logic [RW-1:0]       cur_row;
  logic [DIST_W-1:0]   cur_dist;
  logic [DIST_W-1:0]   largest;
  logic [SPW-1:0]      sp;
  logic                run_done;
  logic [MAX_COLS-1:0] row_bits;   // visited bits of the current row

  // clearing pass and read tracking
  logic          clearing;
  logic [RW-1:0] clr_cnt;
  logic          rd_ok;           // memory read data matches current state

  // memories
  logic [MAX_COLS-1:0] vis_mem [MAX_ROWS];
  logic [STK_W-1:0]    stk_mem [STACK_DEPTH];
  logic [MAX_COLS-1:0] up_q;
  logic [MAX_COLS-1:0] dn_q;
  logic [STK_W-1:0]    stk_q;

  // clamped configuration
  logic [CUW-1:0] cols_used;
  logic [RUW-1:0] rows_used;
  logic [CW-1:0]  start_c;
  logic [RW-1:0]  start_r;

  always_comb begin
    if (grid_cols == '0) begin
      cols_used = CUW'(1);
    end else if (CMP_W'(grid_cols) > CMP_W'(MAX_COLS)) begin
      cols_used = CUW'(MAX_COLS);
    end else begin
      cols_used = CUW'(grid_cols);
    end
    if (grid_rows == '0) begin
      rows_used = RUW'(1);
    end else if (CMP_W'(grid_rows) > CMP_W'(MAX_ROWS)) begin
      rows_used = RUW'(MAX_ROWS);
    end else begin
      rows_used = RUW'(grid_rows);
    end
    if (CMP_W'(start_col) >= CMP_W'(cols_used)) begin
      start_c = CW'(cols_used - CUW'(1));
    end else begin
      start_c = CW'(start_col);
    end
    if (CMP_W'(start_row) >= CMP_W'(rows_used)) begin
      start_r = RW'(rows_used - RUW'(1));
    end else begin
      start_r = RW'(start_row);
    end
  end

  // read addresses follow the current state; edge rows read a harmless row
  logic [RW-1:0]  up_addr;
  logic [RW-1:0]  dn_addr;
  logic [SAW-1:0] pop_addr;

  always_comb begin
    up_addr  = (cur_row == '0) ? '0 : cur_row - RW'(1);
    dn_addr  = (cur_row == RW'(MAX_ROWS - 1)) ? '0 : cur_row + RW'(1);
    pop_addr = SAW'(sp - SPW'(2));
  end

  // step logic
  logic                 acc;
  logic [MAX_COLS-1:0]  row_mark;
  logic [3:0]           blk;
  logic                 dead;
  dir_t                 dir;
  logic [CW-1:0]        pop_col;
  logic [RW-1:0]        pop_row;
  logic [DIST_W-1:0]    pop_dist;
  logic [CW-1:0]        new_col;
  logic [RW-1:0]        new_row;
  logic [DIST_W-1:0]    carve_dist;

  logic [CW-1:0]        cur_col_next;
  logic [RW-1:0]        cur_row_next;
  logic [DIST_W-1:0]    cur_dist_next;
  logic [DIST_W-1:0]    largest_next;
  logic [SPW-1:0]       sp_next;
  logic                 run_done_next;
  logic [MAX_COLS-1:0]  row_bits_next;
  logic                 vis_we;
  logic                 stk_we;
  event_kind_t          kind;
  logic [1:0]           cdir;
  logic [DIST_W-1:0]    cdist;

  assign s_tready = rd_ok && !clearing && (!m_tvalid || m_tready);
  assign acc      = s_tvalid && s_tready;
  assign dir      = dir_t'(s_tdata[1:0]);

  always_comb begin
    row_mark          = row_bits;
    row_mark[cur_col] = 1'b1;

    blk[DIR_LEFT]  = (cur_col == '0) || row_mark[cur_col - CW'(1)];
    blk[DIR_RIGHT] = !((CUW'(cur_col) + CUW'(1)) < cols_used)
                     || row_mark[cur_col + CW'(1)];
    blk[DIR_UP]    = (cur_row == '0) || up_q[cur_col];
    blk[DIR_DOWN]  = !((RUW'(cur_row) + RUW'(1)) < rows_used) || dn_q[cur_col];
    dead = &blk;

    // parent entry; the lower floor copy of the start cell is not stored
    if (sp == SPW'(3)) begin
      pop_col  = start_c;
      pop_row  = start_r;
      pop_dist = DIST_W'(1);
    end else begin
      {pop_dist, pop_row, pop_col} = stk_q;
    end

    new_col = cur_col;
    new_row = cur_row;
    unique case (dir)
      DIR_LEFT:  new_col = cur_col - CW'(1);
      DIR_RIGHT: new_col = cur_col + CW'(1);
      DIR_UP:    new_row = cur_row - RW'(1);
      DIR_DOWN:  new_row = cur_row + RW'(1);
      default:   new_col = cur_col;
    endcase
    carve_dist = (cur_dist >= DIST_MAX) ? DIST_MAX : cur_dist + DIST_W'(1);

    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    cur_dist_next = cur_dist;
    largest_next  = largest;
    sp_next       = sp;
    run_done_next = run_done;
    row_bits_next = row_bits;
    vis_we        = 1'b0;
    stk_we        = 1'b0;
    kind          = EV_DONE;
    cdir          = '0;
    cdist         = '0;

    if (acc && !run_done) begin
      vis_we        = 1'b1;
      row_bits_next = row_mark;
      if (dead) begin
        kind = EV_BACK;
        if (sp > SPW'(2)) begin
          sp_next       = sp - SPW'(1);
          cur_col_next  = pop_col;
          cur_row_next  = pop_row;
          cur_dist_next = pop_dist;
          // the parent is adjacent, so its row is one of the three at hand
          if (pop_row < cur_row) begin
            row_bits_next = up_q;
          end else if (pop_row > cur_row) begin
            row_bits_next = dn_q;
          end
        end else begin
          run_done_next = 1'b1;
        end
      end else if (blk[dir]) begin
        kind = EV_REJECT;
      end else begin
        kind          = EV_CARVE;
        cdir          = dir;
        cdist         = carve_dist;
        cur_col_next  = new_col;
        cur_row_next  = new_row;
        cur_dist_next = carve_dist;
        if (cur_dist > largest) begin
          largest_next = cur_dist;
        end
        if (sp < SPW'(STACK_DEPTH)) begin
          stk_we  = 1'b1;
          sp_next = sp + SPW'(1);
        end
        if (dir == DIR_UP) begin
          row_bits_next = up_q;
        end else if (dir == DIR_DOWN) begin
          row_bits_next = dn_q;
        end
      end
    end
  end

  // visited map: one row per word, cleared by the pass, marked on each draw until the run is done
  always_ff @(posedge clk) begin
    if (clearing) begin
      vis_mem[clr_cnt] <= '0;
    end else if (vis_we) begin
      vis_mem[cur_row] <= row_mark;
    end
    up_q <= vis_mem[up_addr];
    dn_q <= vis_mem[dn_addr];
  end

  // path stack: entries hold distance, row and column
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[sp[SAW-1:0]] <= {carve_dist, new_row, new_col};
    end
    stk_q <= stk_mem[pop_addr];
  end

  // configuration and control
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= GRID_W'(64);
      grid_rows <= GRID_W'(64);
      start_col <= '0;
      start_row <= '0;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      rd_ok     <= 1'b0;
      m_tvalid  <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      cur_dist  <= DIST_W'(1);
      largest   <= DIST_W'(1);
      sp        <= SPW'(2);
      run_done  <= 1'b0;
      row_bits  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_GRID_COLS: grid_cols <= cfg_wdata;
          REG_GRID_ROWS: grid_rows <= cfg_wdata;
          REG_START_COL: start_col <= cfg_wdata[START_W-1:0];
          REG_START_ROW: start_row <= cfg_wdata[START_W-1:0];
          default:       grid_cols <= grid_cols;
        endcase
        clearing <= 1'b1;
        clr_cnt  <= '0;
      end else if (clearing) begin
        clr_cnt <= clr_cnt + RW'(1);
        if (clr_cnt == RW'(MAX_ROWS - 1)) begin
          clearing <= 1'b0;
        end
      end

      // reads issued this cycle are valid next cycle unless the state moves
      rd_ok <= !(cfg_we || clearing || acc);

      if (clearing) begin
        // restart state follows the configuration until the pass ends
        cur_col  <= start_c;
        cur_row  <= start_r;
        cur_dist <= DIST_W'(1);
        largest  <= DIST_W'(1);
        sp       <= SPW'(2);
        run_done <= 1'b0;
        row_bits <= '0;
      end else begin
        cur_col  <= cur_col_next;
        cur_row  <= cur_row_next;
        cur_dist <= cur_dist_next;
        largest  <= largest_next;
        sp       <= sp_next;
        run_done <= run_done_next;
        row_bits <= row_bits_next;
      end

      if (acc) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (acc) begin
      m_tuser <= kind;
      m_tdata <= OUT_W'({run_done_next, largest_next, cdist, cdir,
                         POS_W'(cur_row_next), POS_W'(cur_col_next)});
    end
  end

  // a draw is never taken on stale read data
  a_no_back_to_back_accept: assert property (@(posedge clk) disable iff (rst)
    acc |=> !s_tready)
    else $error("draw accepted in the cycle after an accepted draw");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("draw accepted during the clearing pass");

  a_stack_floor: assert property (@(posedge clk) disable iff (rst)
    sp >= SPW'(2))
    else $error("path stack popped below its floor");

  a_done_at_start: assert property (@(posedge clk) disable iff (rst)
    run_done && !clearing |-> cur_col == start_c && cur_row == start_r)
    else $error("run finished away from the start cell");

  a_finished_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_BITS-1] |-> m_tuser == EV_BACK || m_tuser == EV_DONE)
    else $error("finished flag with a carve or reject result");

endmodule

// File: tb/sv/tb_maze_backtracker_carver.sv
// self-checking testbench for the depth-first maze carver: directed and random draws
// against an in-bench predictor of the carving walk, with random stalls on both streams
// depends on mbc_pkg (sv/mbc_pkg.sv) and maze_backtracker_carver (sv/maze_backtracker_carver.sv)
`timescale 1ns / 100ps

module tb_maze_backtracker_carver;
  import mbc_pkg::*;

  localparam int COLS        = DEF_MAX_COLS;
  localparam int ROWS        = DEF_MAX_ROWS;
  localparam int CELLS       = COLS * ROWS;
  localparam int STACK_SLOTS = CELLS + 1;
  localparam int HOPS_CAP    = 8191;
  localparam int RANDOM_DRAWS = 1925;
  localparam int PHASE_CAP    = 400;
  localparam int CYCLE_LIMIT  = 400000;

  // one expected result beat, fields as the block reports them
  typedef struct {
    event_kind_t  kind;
    logic [5:0]   col;
    logic [5:0]   row;
    dir_t         carve;
    logic [12:0]  hops;
    logic [12:0]  top_hops;
    logic         fin;
  } carve_result_t;

  // every input known from time zero
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = REG_GRID_COLS;
  logic [GRID_W-1:0] cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;      // [1:0] rand_dir
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  // [5:0] cell_col, [11:6] cell_row, [13:12] carve_dir, [26:14] cell_distance,
  // [39:27] max_distance, [40] finished
  logic [OUT_W-1:0]  m_tdata;
  logic [1:0]        m_tuser;             // [1:0] event_kind

  maze_backtracker_carver DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // carving walk predictor: own copy of registers and maze state
  // ---------------------------------------------------------------------------
  logic [6:0]   grid_cols_r, grid_rows_r;
  logic [5:0]   start_col_r, start_row_r;
  bit           visited [CELLS];
  logic [12:0]  hops_mem [CELLS];
  int unsigned  path_stack [STACK_SLOTS];
  int unsigned  path_depth;
  int unsigned  cur_col, cur_row;
  logic [12:0]  peak_hops;
  bit           maze_done;

  carve_result_t carve_results_q[$];   // expected beats, oldest first

  int unsigned mismatches  = 0;
  int unsigned draws_sent  = 0;
  int unsigned settings    = 0;
  int unsigned mazes_done  = 0;
  int unsigned deepest     = 0;
  int unsigned kind_seen [4];
  int unsigned cycle_cnt   = 0;
  bit          jitter_on   = 1'b0;     // random gaps on sender and receiver

  // grid size clamps to 1..max
  function automatic int unsigned cols_in_use();
    if (grid_cols_r == 0) return 1;
    if (grid_cols_r > COLS) return COLS;
    return grid_cols_r;
  endfunction

  function automatic int unsigned rows_in_use();
    if (grid_rows_r == 0) return 1;
    if (grid_rows_r > ROWS) return ROWS;
    return grid_rows_r;
  endfunction

  function automatic int unsigned cell_at(input int unsigned c, input int unsigned r);
    return (r * COLS + c) % CELLS;
  endfunction

  // fresh walk from the start cell, as after reset or any register write
  function automatic void restart_maze();
    int unsigned sc, sr, s;
    sc = start_col_r;
    sr = start_row_r;
    if (sc >= cols_in_use()) sc = cols_in_use() - 1;
    if (sr >= rows_in_use()) sr = rows_in_use() - 1;
    foreach (visited[i]) visited[i] = 1'b0;
    foreach (hops_mem[i]) hops_mem[i] = '0;
    foreach (path_stack[i]) path_stack[i] = 0;
    cur_col = sc;
    cur_row = sr;
    s = cell_at(sc, sr);
    hops_mem[s] = 13'd1;
    // start cell sits twice: the lower copy is the floor that is never popped
    path_stack[0] = s;
    path_stack[1] = s;
    path_depth = 2;
    peak_hops = 13'd1;
    maze_done = 1'b0;
  endfunction

  // neighbor of the current cell; 0 when it would leave the grid
  function automatic bit step_to(input dir_t d, output int unsigned nc,
                                 output int unsigned nr);
    nc = cur_col;
    nr = cur_row;
    case (d)
      DIR_LEFT: begin
        if (nc == 0) return 1'b0;
        nc = nc - 1;
      end
      DIR_RIGHT: begin
        if (nc + 1 >= cols_in_use()) return 1'b0;
        nc = nc + 1;
      end
      DIR_UP: begin
        if (nr == 0) return 1'b0;
        nr = nr - 1;
      end
      default: begin
        if (nr + 1 >= rows_in_use()) return 1'b0;
        nr = nr + 1;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic bit is_blocked(input dir_t d);
    int unsigned nc, nr;
    if (!step_to(d, nc, nr)) return 1'b1;
    return visited[cell_at(nc, nr)];
  endfunction

  // one draw through the walk: returns the beat the block should send back
  function automatic carve_result_t predict_draw(input dir_t d);
    carve_result_t res;
    int unsigned   here, nc, nr, nidx, prev_hops, new_hops, top;
    bit            dead;
    int            k;
    res.kind  = EV_DONE;
    res.carve = DIR_LEFT;
    res.hops  = '0;
    if (!maze_done) begin
      here = cell_at(cur_col, cur_row);
      visited[here] = 1'b1;
      dead = 1'b1;
      for (k = 0; k < 4; k++)
        if (!is_blocked(dir_t'(k))) dead = 1'b0;
      if (dead) begin
        // dead end: step back along the path, or finish on the start floor
        res.kind = EV_BACK;
        if (path_depth > 2) begin
          path_depth--;
          top = path_stack[(path_depth - 1) % STACK_SLOTS];
          cur_col = top % COLS;
          cur_row = top / COLS;
        end else begin
          maze_done = 1'b1;
          mazes_done++;
        end
      end else if (is_blocked(d)) begin
        res.kind = EV_REJECT;
      end else begin
        void'(step_to(d, nc, nr));
        prev_hops = hops_mem[here];
        // the peak follows the cell carved from, not the new one
        if (prev_hops > peak_hops) peak_hops = 13'(prev_hops);
        new_hops = (prev_hops >= HOPS_CAP) ? HOPS_CAP : prev_hops + 1;
        cur_col = nc;
        cur_row = nr;
        nidx = cell_at(nc, nr);
        hops_mem[nidx] = 13'(new_hops);
        if (path_depth < STACK_SLOTS) begin
          path_stack[path_depth] = nidx;
          path_depth++;
        end
        if (new_hops > deepest) deepest = new_hops;
        res.kind  = EV_CARVE;
        res.carve = d;
        res.hops  = 13'(new_hops);
      end
    end
    res.col      = 6'(cur_col);
    res.row      = 6'(cur_row);
    res.top_hops = peak_hops;
    res.fin      = maze_done;
    kind_seen[res.kind]++;
    return res;
  endfunction

  // a draw that leads somewhere new when one exists, so the walk goes deep
  function automatic dir_t pick_open_dir();
    dir_t open_dirs[$];
    int   k;
    for (k = 0; k < 4; k++)
      if (!is_blocked(dir_t'(k))) open_dirs.push_back(dir_t'(k));
    if (maze_done || open_dirs.size() == 0) return dir_t'($urandom_range(0, 3));
    return open_dirs[$urandom_range(0, open_dirs.size() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one draw beat; tvalid stays high so back-to-back draws need no re-raise
  task automatic send_draw(input dir_t d);
    s_tdata  <= {6'd0, d};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    carve_results_q.push_back(predict_draw(d));
    draws_sent++;
  endtask

  task automatic sender_gap();
    s_tvalid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  // hold off the sender until every expected beat has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (carve_results_q.size() != 0) @(posedge clk);
  endtask

  // one register write; caller drops the write enable after a batch
  task automatic write_reg(input cfg_reg_t idx, input logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_GRID_COLS: grid_cols_r = val;
      REG_GRID_ROWS: grid_rows_r = val;
      REG_START_COL: start_col_r = val[5:0];
      default:       start_row_r = val[5:0];
    endcase
    restart_maze();
  endtask

  // new grid setting, only once the block has gone quiet
  task automatic setup_grid(input logic [6:0] cols, input logic [6:0] rows,
                            input logic [6:0] scol, input logic [6:0] srow);
    settle();
    write_reg(REG_GRID_COLS, cols);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_START_COL, scol);
    write_reg(REG_START_ROW, srow);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // reset values: 64 by 64 from the corner, edges, a visited cell and carving right, down and left
  task automatic test_reset_grid();
    send_draw(DIR_LEFT);    // off the left edge
    send_draw(DIR_UP);      // off the top edge
    send_draw(DIR_RIGHT);
    send_draw(DIR_DOWN);
    send_draw(DIR_LEFT);
    send_draw(DIR_UP);      // back into a visited cell
    send_draw(DIR_DOWN);
    send_draw(DIR_RIGHT);
    settings++;
  endtask

  // one-cell grid: first draw finishes the maze, the rest answer as done
  task automatic test_single_cell();
    setup_grid(7'd1, 7'd1, 7'd5, 7'd5);
    send_draw(DIR_RIGHT);
    send_draw(DIR_DOWN);
    send_draw(DIR_UP);
    send_draw(DIR_LEFT);
  endtask

  // three-cell corridor from the middle: backtrack onto the start while the
  // left side is still open must not end the run; includes a full hold-off
  task automatic test_corridor_return();
    setup_grid(7'd3, 7'd1, 7'd1, 7'd0);
    send_draw(DIR_RIGHT);
    settle();
    send_draw(DIR_UP);      // dead end, back onto the start cell
    send_draw(DIR_LEFT);
    send_draw(DIR_DOWN);    // dead end, back to start again
    send_draw(DIR_RIGHT);   // start is a dead end now: maze complete
    send_draw(DIR_LEFT);
  endtask

  // size registers out of range and start outside the grid
  task automatic test_clamping();
    // zero columns act as one, start column saturates, start row masked to 6 bits
    setup_grid(7'd0, 7'd127, 7'd127, 7'd100);
    send_draw(DIR_UP);
    send_draw(DIR_DOWN);
    send_draw(DIR_LEFT);
    // columns above max act as max, start row saturates to the last row
    setup_grid(7'd65, 7'd2, 7'd64, 7'd63);
    send_draw(DIR_RIGHT);
    send_draw(DIR_UP);
  endtask

  function automatic logic [6:0] random_size();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 7'($urandom_range(1, 8));
    if (pick < 9) return 7'($urandom_range(1, 24));
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd65;
      4:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // mostly small mazes walked to completion with draws steered at open
  // neighbors, plus plain random draws, a few large grids and lone reg writes
  task automatic test_random_mazes();
    int unsigned drawn, n, tail;
    logic [6:0]  val;
    dir_t        d;
    drawn = 0;
    while (drawn < RANDOM_DRAWS) begin
      // last stretch runs at full rate on both sides
      jitter_on = (drawn < RANDOM_DRAWS * 85 / 100) && ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0) begin
        settle();
        val = 7'($urandom_range(0, 127));
        write_reg(cfg_reg_t'($urandom_range(0, 3)), val);
        cfg_we <= 1'b0;
        settings++;
      end else begin
        setup_grid(random_size(), random_size(), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)));
      end
      n = 0;
      tail = $urandom_range(1, 4);
      while (drawn < RANDOM_DRAWS && n < PHASE_CAP && tail > 0) begin
        if (maze_done) tail--;
        if (jitter_on && $urandom_range(0, 3) == 0) sender_gap();
        if ((drawn < RANDOM_DRAWS * 85 / 100) && $urandom_range(0, 63) == 0) settle();
        d = ($urandom_range(0, 3) != 0) ? pick_open_dir() : dir_t'($urandom_range(0, 3));
        send_draw(d);
        n++;
        drawn++;
      end
    end
    jitter_on = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts on m_tready while jitter is on
  // ---------------------------------------------------------------------------
  always begin
    @(posedge clk);
    if (jitter_on && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    m_tready <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // result checker: each accepted beat against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic cmp_field(input string name, input int unsigned want,
                           input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_beat
    carve_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (carve_results_q.size() == 0) begin
        $error("result beat with nothing expected: tuser %0d tdata %h", m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = carve_results_q.pop_front();
        cmp_field("event_kind",    want.kind,     m_tuser);
        cmp_field("cell_col",      want.col,      m_tdata[5:0]);
        cmp_field("cell_row",      want.row,      m_tdata[11:6]);
        cmp_field("carve_dir",     want.carve,    m_tdata[13:12]);
        cmp_field("cell_distance", want.hops,     m_tdata[26:14]);
        cmp_field("max_distance",  want.top_hops, m_tdata[39:27]);
        cmp_field("finished",      want.fin,      m_tdata[40]);
      end
    end
  end

  // watchdog covers the clearing pass after each write and all stall bursts
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
               carve_results_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    int guard;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    grid_cols_r = 7'd64;
    grid_rows_r = 7'd64;
    start_col_r = 6'd0;
    start_row_r = 6'd0;
    restart_maze();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_grid();
    test_single_cell();
    test_corridor_return();
    test_clamping();
    test_random_mazes();

    // drain, then allow the output register to settle
    s_tvalid <= 1'b0;
    for (guard = 0; guard < 5000 && carve_results_q.size() != 0; guard++)
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (carve_results_q.size() != 0) begin
      $error("%0d expected result beats never arrived", carve_results_q.size());
      mismatches++;
    end

    $display("%0d draws over %0d register settings: %0d carved, %0d rejected, %0d backtracked",
             draws_sent, settings, kind_seen[EV_CARVE], kind_seen[EV_REJECT],
             kind_seen[EV_BACK]);
    $display("%0d mazes completed, %0d draws after completion, longest distance %0d",
             mazes_done, kind_seen[EV_DONE], deepest);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/mbc_pkg.sv
sv/maze_backtracker_carver.sv
tb/sv/tb_maze_backtracker_carver.sv
